// ===== rtl/core/gcc_pkg.sv =====
// package for the graph connectivity checker
// field widths, defaults and operation codes; no dependencies
package gcc_pkg;

  localparam int MAX_V_DEF = 32;

  localparam int MODE_W = 2;
  localparam int VTX_W  = 5;
  localparam int NV_W   = 6;
  localparam int CNT_W  = 7;

  localparam logic [NV_W-1:0] NV_RESET = 6'd32;

  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

endpackage

// ===== rtl/core/graph_connectivity_checker.sv =====
// graph connectivity checker top level
// adjacency row memory, edge update sequencer and reachability sweep
// depends on gcc_pkg
//
// usage: an input transaction carries mode, vertex_a and vertex_b. add and
// remove update both mirrored bits of the adjacency matrix and give no
// result. a check gives one output transaction with connected.
// the user must write num_vertices through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce it. add or remove goes
// through S_RDA, S_WRA and S_WRB (S_WRB is skipped for a self loop). a
// check sweeps the rows of the vertices in use through the single read port
// of the row memory (n = vertices in use) and repeats passes until one pass
// adds no vertex: at most n passes. with n zero there is no sweep and
// connected is given as true. in_ready is high only between items. a
// finished result sits in the output register; the next item is accepted
// meanwhile, but a following check holds its result until the receiver takes the pending one.
// reset clears the row valid bits (the matrix reads as empty), the reached
// set and the output, and sets num_vertices to 32.
module graph_connectivity_checker #(
  parameter int MAX_V = gcc_pkg::MAX_V_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [gcc_pkg::NV_W-1:0]   cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [gcc_pkg::MODE_W-1:0] mode,
  input  logic [gcc_pkg::VTX_W-1:0]  vertex_a,
  input  logic [gcc_pkg::VTX_W-1:0]  vertex_b,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       connected
);
  import gcc_pkg::*;

  localparam int VW = $clog2(MAX_V);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDA  = 3'd1;
  localparam logic [2:0] S_WRA  = 3'd2;
  localparam logic [2:0] S_WRB  = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]       state;
  logic [NV_W-1:0]  num_vertices;
  logic [MAX_V-1:0] mem [MAX_V];
  logic [MAX_V-1:0] row_valid;
  logic [MAX_V-1:0] rd_data;
  logic             rd_vld;
  logic [VW-1:0]    rd_addr;
  logic             mem_we;
  logic [VW-1:0]    wr_addr;
  logic [MAX_V-1:0] wr_data;
  logic [MAX_V-1:0] base_row;
  logic [VW-1:0]    ea;
  logic [VW-1:0]    eb;
  logic             eset;
  logic [MAX_V-1:0] reached;
  logic [MAX_V-1:0] grown;
  logic [MAX_V-1:0] mask;
  logic [VW-1:0]    idx;
  logic [VW-1:0]    pidx;
  logic             issue_on;
  logic             pend;
  logic             changed;
  logic             result;
  logic [CNT_W-1:0] n_used;
  logic [VW-1:0]    n_last;
  logic             a_ok;
  logic             b_ok;
  logic             in_fire;
  logic             out_load;

  assign n_used = (CNT_W'(num_vertices) > CNT_W'(MAX_V)) ? CNT_W'(MAX_V)
                                                          : CNT_W'(num_vertices);
  assign n_last = VW'(n_used - CNT_W'(1));
  assign a_ok   = CNT_W'(vertex_a) < n_used;
  assign b_ok   = CNT_W'(vertex_b) < n_used;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_load = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    for (int v = 0; v < MAX_V; v++) begin
      mask[v] = CNT_W'(v) < n_used;
    end
  end

  assign base_row = rd_vld ? rd_data : '0;
  assign grown = reached | ((pend && rd_vld && reached[pidx]) ? (rd_data & mask) : '0);

  always_comb begin
    rd_addr = idx;
    mem_we  = 1'b0;
    wr_addr = ea;
    wr_data = base_row;
    case (state)
      S_RDA: begin
        rd_addr = ea;
      end
      S_WRA: begin
        rd_addr = eb;
        mem_we  = 1'b1;
        wr_addr = ea;
        for (int i = 0; i < MAX_V; i++) begin
          wr_data[i] = (VW'(i) == eb) ? eset : base_row[i];
        end
      end
      S_WRB: begin
        mem_we  = 1'b1;
        wr_addr = eb;
        for (int i = 0; i < MAX_V; i++) begin
          wr_data[i] = (VW'(i) == ea) ? eset : base_row[i];
        end
      end
      default: begin
        rd_addr = idx;
      end
    endcase
  end

  // row memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
    rd_vld  <= row_valid[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= NV_RESET;
    end else if (cfg_we) begin
      num_vertices <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      reached  <= '0;
      issue_on <= 1'b0;
      pend     <= 1'b0;
      changed  <= 1'b0;
      idx      <= '0;
      pidx     <= '0;
      result   <= 1'b0;
      ea       <= '0;
      eb       <= '0;
      eset     <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            if ((mode == MODE_ADD || mode == MODE_REMOVE) && a_ok && b_ok) begin
              ea    <= VW'(vertex_a);
              eb    <= VW'(vertex_b);
              eset  <= (mode == MODE_ADD);
              state <= S_RDA;
            end else if (mode == MODE_CHECK) begin
              if (n_used == '0) begin
                reached <= '0;
                result  <= 1'b1;
                state   <= S_FIN;
              end else begin
                reached  <= MAX_V'(1);
                idx      <= '0;
                issue_on <= 1'b1;
                pend     <= 1'b0;
                changed  <= 1'b0;
                state    <= S_RUN;
              end
            end
          end
        end
        S_RDA: begin
          state <= S_WRA;
        end
        S_WRA: begin
          state <= (ea == eb) ? S_IDLE : S_WRB;
        end
        S_WRB: begin
          state <= S_IDLE;
        end
        S_RUN: begin
          if (issue_on) begin
            pidx <= idx;
            pend <= 1'b1;
            if (idx == n_last) begin
              issue_on <= 1'b0;
            end else begin
              idx <= idx + VW'(1);
            end
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            reached <= grown;
            if (pidx == n_last) begin
              if (changed || (grown != reached)) begin
                idx      <= '0;
                issue_on <= 1'b1;
                changed  <= 1'b0;
              end else begin
                result <= (grown == mask);
                state  <= S_FIN;
              end
            end else begin
              changed <= changed || (grown != reached);
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      connected <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
      connected <= result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_write_only_on_edge: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_WRA || state == S_WRB))
    else $error("row write outside an edge update");

  a_start_reached: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> reached[0])
    else $error("vertex 0 missing from reached set during a sweep");

  a_reached_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && $past(state) == S_RUN) |-> ((reached & $past(reached)) == $past(reached)))
    else $error("reached set lost a vertex during a sweep");

  a_issue_in_sweep: assert property (@(posedge clk) disable iff (rst)
    issue_on |-> (state == S_RUN))
    else $error("row read issued outside a sweep");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("finished check did not reach the output register");

endmodule
